// File: rtl/auart_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// auart_pkg
// shared types and constants of the serial adapter register block
// ---------------------------------------------------------------------------
package auart_pkg;

    localparam int RING_SLOTS = 16;
    localparam int PTR_W      = $clog2(RING_SLOTS);

    typedef logic [PTR_W-1:0] t_ptr;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_RX    = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    localparam logic [15:0] OFF_DATA    = 16'd0;
    localparam logic [15:0] OFF_STATUS  = 16'd1;
    localparam logic [15:0] OFF_COMMAND = 16'd2;
    localparam logic [15:0] OFF_CONTROL = 16'd3;

    localparam logic [7:0] CMD_RESET      = 8'h02;
    localparam logic [7:0] CMD_KEEP_MASK  = 8'h70;
    localparam logic [7:0] CTRL_RESET     = 8'h00;
    localparam logic [7:0] ST_TX_EMPTY    = 8'h10;
    localparam logic [7:0] ST_RX_FULL     = 8'h08;
    localparam logic [7:0] ST_OVERRUN     = 8'h04;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } t_ring_ctl;

    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } t_ring_sts;

    function automatic t_ptr ptr_next(input t_ptr p);
        t_ptr r;
        if (p == t_ptr'(RING_SLOTS - 1)) begin
            r = '0;
        end else begin
            r = p + t_ptr'(1);
        end
        return r;
    endfunction

endpackage

// File: rtl/auart_rx_ring.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// auart_rx_ring
// receive ring: slot storage with head and tail pointers, one slot spare
// ---------------------------------------------------------------------------
module auart_rx_ring
    import auart_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ring_ctl i_ctl,
    input  logic [7:0] i_data,
    output t_ring_sts o_sts,
    output logic [7:0] o_data
);

    logic [7:0] r_slot [RING_SLOTS];
    t_ptr       r_head;
    t_ptr       r_tail;
    t_ptr       n_head;
    t_ptr       n_tail;

    always_comb begin
        o_sts.empty = (r_head == r_tail);
        o_sts.full  = (ptr_next(r_head) == r_tail);
        o_sts.last  = (ptr_next(r_tail) == r_head);
        o_data      = r_slot[r_tail];
    end

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_ctl.flush) begin
            n_head = '0;
            n_tail = '0;
        end else begin
            if (i_ctl.push && !o_sts.full) begin
                n_head = ptr_next(r_head);
            end
            if (i_ctl.pop && !o_sts.empty) begin
                n_tail = ptr_next(r_tail);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !i_ctl.flush && !o_sts.full) begin
            r_slot[r_head] <= i_data;
        end
    end

endmodule

// File: rtl/acia_uart_rx_fifo_registers.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acia_uart_rx_fifo_registers
// register face of a serial adapter with a receive ring
// ---------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one word per bus read,
// bus write or byte received from the line: i_kind, i_address, i_data.
// Output channel (o_out_valid / i_out_ready) returns one word per input
// word: o_read_data, o_tx_valid, o_tx_byte.
// The configuration channel (i_cfg_valid / o_cfg_ready) sets the base
// address of the four registers; it is always ready. The user must see that
// it is written only while the block is idle; the block does not enforce it.
// A word passes an input register and then the decode and register update
// logic that loads the output register; one word is taken every cycle
// while the receiver keeps taking output words.
// The ring holds up to RING_SLOTS-1 received bytes; a byte into a full
// ring is dropped and raises overrun.
// When the receiver stalls, the output word holds and the input register
// fills; o_in_ready then drops until the output moves.
// Synchronous reset empties the ring and restores status 0x10, command 0x02,
// control 0 and base address 0; no clearing pass is needed.
// ---------------------------------------------------------------------------
module acia_uart_rx_fifo_registers
    import auart_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_base_address
);

    logic        r_s1_valid;
    logic [1:0]  r_s1_kind;
    logic [15:0] r_s1_addr;
    logic [7:0]  r_s1_data;

    logic [15:0] r_base;
    logic [7:0]  r_command;
    logic [7:0]  r_control;
    logic        r_overrun;
    logic        r_rx_full;

    logic        r_out_valid;
    logic [7:0]  r_read_data;
    logic        r_tx_valid;
    logic [7:0]  r_tx_byte;

    logic        out_load;
    logic        s1_fire;
    logic [15:0] offset;
    logic [7:0]  status;
    t_ring_ctl   ring_ctl;
    t_ring_sts   ring_sts;
    logic [7:0]  ring_data;

    logic [7:0]  n_read_data;
    logic        n_tx_valid;
    logic [7:0]  n_tx_byte;
    logic [7:0]  n_command;
    logic [7:0]  n_control;
    logic        n_overrun;
    logic        n_rx_full;

    assign out_load    = !r_out_valid || i_out_ready;
    assign s1_fire     = r_s1_valid && out_load;
    assign o_in_ready  = !r_s1_valid || out_load;
    assign o_cfg_ready = 1'b1;

    assign offset = r_s1_addr - r_base;
    assign status = ST_TX_EMPTY | (r_rx_full ? ST_RX_FULL : 8'h00)
                  | (r_overrun ? ST_OVERRUN : 8'h00);

    auart_rx_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ring_ctl),
        .i_data  (r_s1_data),
        .o_sts   (ring_sts),
        .o_data  (ring_data)
    );

    always_comb begin
        ring_ctl    = '0;
        n_read_data = 8'h00;
        n_tx_valid  = 1'b0;
        n_tx_byte   = 8'h00;
        n_command   = r_command;
        n_control   = r_control;
        n_overrun   = r_overrun;
        n_rx_full   = r_rx_full;
        if (s1_fire) begin
            case (t_kind'(r_s1_kind))
                KIND_READ: begin
                    case (offset)
                        OFF_DATA: begin
                            if (!ring_sts.empty) begin
                                n_read_data  = ring_data;
                                ring_ctl.pop = 1'b1;
                                if (ring_sts.last) begin
                                    n_rx_full = 1'b0;
                                end
                            end
                        end
                        OFF_STATUS:  n_read_data = status;
                        OFF_COMMAND: n_read_data = r_command;
                        OFF_CONTROL: n_read_data = r_control;
                        default:     n_read_data = 8'h00;
                    endcase
                end
                KIND_WRITE: begin
                    case (offset)
                        OFF_DATA: begin
                            n_tx_valid = 1'b1;
                            n_tx_byte  = r_s1_data;
                        end
                        OFF_STATUS: begin
                            n_command      = (r_command & CMD_KEEP_MASK) | CMD_RESET;
                            n_overrun      = 1'b0;
                            ring_ctl.flush = 1'b1;
                        end
                        OFF_COMMAND: n_command = r_s1_data;
                        OFF_CONTROL: n_control = r_s1_data;
                        default:     n_command = r_command;
                    endcase
                end
                KIND_RX: begin
                    if (ring_sts.full) begin
                        n_overrun = 1'b1;
                    end else begin
                        ring_ctl.push = 1'b1;
                        n_rx_full     = 1'b1;
                    end
                end
                default: n_tx_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_base      <= 16'h0000;
            r_command   <= CMD_RESET;
            r_control   <= CTRL_RESET;
            r_overrun   <= 1'b0;
            r_rx_full   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
            if (i_cfg_valid) begin
                r_base <= i_cfg_base_address;
            end
            r_command <= n_command;
            r_control <= n_control;
            r_overrun <= n_overrun;
            r_rx_full <= n_rx_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_kind <= i_kind;
            r_s1_addr <= i_address;
            r_s1_data <= i_data;
        end
        if (s1_fire) begin
            r_read_data <= n_read_data;
            r_tx_valid  <= n_tx_valid;
            r_tx_byte   <= n_tx_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_tx_valid  = r_tx_valid;
    assign o_tx_byte   = r_tx_byte;

    // a sent byte never carries read data
    a_tx_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_valid |-> o_read_data == 8'h00)
        else $error("tx word carries read data");

    // idle tx lane stays zero
    a_tx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tx_valid |-> o_tx_byte == 8'h00)
        else $error("tx byte without tx valid");

    // program reset clears overrun and empties the ring
    a_prog_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_ctl.flush |=> !r_overrun && ring_sts.empty)
        else $error("program reset left ring or overrun");

    // a stalled word in the input register is kept
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_load |=> r_s1_valid && $stable(r_s1_addr))
        else $error("input register lost a word");

    // overrun only rises on a byte into a full ring
    a_overrun_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_overrun && n_overrun |-> ring_sts.full && s1_fire)
        else $error("overrun without full ring");

endmodule
